[rtl/tsdc_pkg.sv]
// ----------------------------------------------------------------------------
// tsdc_pkg: shared types and constants for the thermostat controller
// Event codes, register indexes, field widths, reset values and the status
// bundle passed from the sample averager to the control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdc_pkg;

  // Event kinds carried by one input transaction.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_UP     = 2'd2,
    OP_DOWN   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MIN_SETPOINT  = 2'd0,
    CFG_MAX_SETPOINT  = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2,
    CFG_SENSOR_OFFSET = 2'd3
  } cfg_idx_t;

  localparam int unsigned TEMP_W    = 8;
  localparam int unsigned AVG_W     = 9;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned SUM_W     = 12;

  // Reciprocal division: mean = (sum * ceil(2^16 / N)) >> 16, exact for any
  // 12-bit sum as long as N <= 16.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 17;

  localparam logic [TEMP_W-1:0] MIN_SETPOINT_RST  = 8'd10;
  localparam logic [TEMP_W-1:0] MAX_SETPOINT_RST  = 8'd40;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd5000;
  localparam logic [TEMP_W-1:0] SENSOR_OFFSET_RST = 8'd5;
  localparam logic [TEMP_W-1:0] SETPOINT_RST      = 8'd20;

  // Averager status after the current event.
  typedef struct packed {
    logic                    done;
    logic signed [AVG_W-1:0] average;
  } avg_status_t;

endpackage : tsdc_pkg

`default_nettype wire

[rtl/tsdc_avg.sv]
// ----------------------------------------------------------------------------
// tsdc_avg: ten-sample (or N-sample) temperature averager
// Accumulates samples, forms the truncated group mean with a reciprocal
// multiply, subtracts the sensor offset and holds the latest average.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdc_avg #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           sample_en,
  input  wire logic [tsdc_pkg::TEMP_W-1:0]    sample,
  input  wire logic [tsdc_pkg::TEMP_W-1:0]    offset,
  output tsdc_pkg::avg_status_t               status
);

  localparam int unsigned IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned RECIP = ((1 << tsdc_pkg::RECIP_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int unsigned PROD_W = tsdc_pkg::SUM_W + tsdc_pkg::RECIP_W;

  localparam logic [tsdc_pkg::RECIP_W-1:0] RECIP_C   = tsdc_pkg::RECIP_W'(RECIP);
  localparam logic [IDX_W:0]               SAMPLES_C = (IDX_W + 1)'(SAMPLES);

  logic [tsdc_pkg::SUM_W-1:0]         sum_r, sum_nxt, sum_add;
  logic [IDX_W-1:0]                   idx_r, idx_nxt;
  logic [IDX_W:0]                     idx_inc;
  logic signed [tsdc_pkg::AVG_W-1:0]  avg_r, avg_nxt, avg_calc;
  logic [PROD_W-1:0]                  product;
  logic [tsdc_pkg::TEMP_W-1:0]        mean;
  logic                               group_end;

  always_comb begin
    sum_add   = sum_r + {{(tsdc_pkg::SUM_W - tsdc_pkg::TEMP_W){1'b0}}, sample};
    idx_inc   = {1'b0, idx_r} + {{IDX_W{1'b0}}, 1'b1};
    group_end = sample_en && (idx_inc >= SAMPLES_C);

    // The sum never exceeds 16 * 255, so the mean always fits in eight bits.
    product = {{tsdc_pkg::RECIP_W{1'b0}}, sum_add} * {{tsdc_pkg::SUM_W{1'b0}}, RECIP_C};
    mean    = product[tsdc_pkg::RECIP_SHIFT +: tsdc_pkg::TEMP_W];
    avg_calc = $signed({1'b0, mean}) - $signed({1'b0, offset});

    sum_nxt = sum_r;
    idx_nxt = idx_r;
    avg_nxt = avg_r;
    if (group_end) begin
      sum_nxt = '0;
      idx_nxt = '0;
      avg_nxt = avg_calc;
    end else if (sample_en) begin
      sum_nxt = sum_add;
      idx_nxt = idx_inc[IDX_W-1:0];
    end

    status.done    = group_end;
    status.average = avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
      avg_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
      avg_r <= avg_nxt;
    end
  end

endmodule : tsdc_avg

`default_nettype wire

[rtl/thermostat_setpoint_deadband_control.sv]
// An accepted input transaction has its result on out_* in the cycle after it.
// Throughput: one transaction per cycle; the only limit is out_stall, which
// holds the single output register and stalls the input in the same cycle.
// Reset (synchronous, rst_n low): setpoint 20, adjust mode off, accumulator
// and average cleared, configuration back to 10 / 40 / 5000 / 5, no result.
// ----------------------------------------------------------------------------
// thermostat_setpoint_deadband_control: bang-bang thermostat with dead band
// Takes tick, sample and button events, keeps the setpoint and adjust mode,
// averages samples in groups and drives heater and cooler decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_setpoint_deadband_control #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  // Event input channel.
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [1:0]                          in_op,
  input  wire logic [tsdc_pkg::TEMP_W-1:0]         in_sample,

  // Result channel.
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic                                out_heater_on,
  output      logic                                out_cooler_on,
  output      logic                                out_adjust_mode,
  output      logic [tsdc_pkg::TEMP_W-1:0]         out_setpoint,
  output      logic signed [tsdc_pkg::AVG_W-1:0]   out_average_temp,
  output      logic                                out_average_done,

  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [tsdc_pkg::CFG_W-1:0]          cfg_wdata
);

  // --------------------------------------------------------------------------
  // Handshake. A new transaction is taken whenever the output register is
  // empty or its current result is being taken in this same cycle.
  // --------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tsdc_pkg::op_t in_op_e;
  assign in_op_e = tsdc_pkg::op_t'(in_op);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are only expected while the block idles.
  // --------------------------------------------------------------------------
  logic [tsdc_pkg::TEMP_W-1:0] min_sp_r;
  logic [tsdc_pkg::TEMP_W-1:0] max_sp_r;
  logic [tsdc_pkg::TICK_W-1:0] timeout_r;
  logic [tsdc_pkg::TEMP_W-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sp_r  <= tsdc_pkg::MIN_SETPOINT_RST;
      max_sp_r  <= tsdc_pkg::MAX_SETPOINT_RST;
      timeout_r <= tsdc_pkg::TIMEOUT_TICKS_RST;
      offset_r  <= tsdc_pkg::SENSOR_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tsdc_pkg::cfg_idx_t'(cfg_index))
        tsdc_pkg::CFG_MIN_SETPOINT:  min_sp_r  <= cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::CFG_MAX_SETPOINT:  max_sp_r  <= cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata;
        tsdc_pkg::CFG_SENSOR_OFFSET: offset_r  <= cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample averaging lives in its own unit; it reports the average as it
  // stands after this transaction and whether this sample closed a group.
  // --------------------------------------------------------------------------
  tsdc_pkg::avg_status_t avg_status;

  tsdc_avg #(
    .SAMPLES (SAMPLES_PER_AVERAGE)
  ) u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (in_accept && (in_op_e == tsdc_pkg::OP_SAMPLE)),
    .sample    (in_sample),
    .offset    (offset_r),
    .status    (avg_status)
  );

  // --------------------------------------------------------------------------
  // Setpoint and adjust-mode control.
  // --------------------------------------------------------------------------
  logic [tsdc_pkg::TEMP_W-1:0] target_r, target_nxt;
  logic                        mode_r, mode_nxt;
  logic [tsdc_pkg::TICK_W-1:0] idle_r, idle_nxt;
  logic [tsdc_pkg::TICK_W:0]   idle_inc;

  always_comb begin
    target_nxt = target_r;
    mode_nxt   = mode_r;
    idle_nxt   = idle_r;
    idle_inc   = {1'b0, idle_r} + {{tsdc_pkg::TICK_W{1'b0}}, 1'b1};

    if (in_accept) begin
      case (in_op_e)
        tsdc_pkg::OP_TICK: begin
          // Only adjust mode counts idle time. A timeout of zero ends the mode
          // on the first tick, just like a timeout of one.
          if (mode_r) begin
            if (idle_inc >= {1'b0, timeout_r}) begin
              mode_nxt = 1'b0;
              idle_nxt = '0;
            end else begin
              idle_nxt = idle_inc[tsdc_pkg::TICK_W-1:0];
            end
          end
        end
        tsdc_pkg::OP_SAMPLE: ;
        tsdc_pkg::OP_UP, tsdc_pkg::OP_DOWN: begin
          // The first press only wakes adjust mode; later presses step the
          // setpoint toward their own limit and never past it.
          if (!mode_r) begin
            mode_nxt = 1'b1;
          end else if (in_op_e == tsdc_pkg::OP_UP) begin
            if (target_r < max_sp_r) begin
              target_nxt = target_r + 8'd1;
            end
          end else begin
            if (target_r > min_sp_r) begin
              target_nxt = target_r - 8'd1;
            end
          end
          idle_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= tsdc_pkg::SETPOINT_RST;
      mode_r   <= 1'b0;
      idle_r   <= '0;
    end else begin
      target_r <= target_nxt;
      mode_r   <= mode_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Dead-band decision on the state after this transaction. The average is
  // signed, so both sides are widened to ten signed bits before comparing.
  // --------------------------------------------------------------------------
  logic signed [tsdc_pkg::AVG_W:0] avg_ext;
  logic signed [tsdc_pkg::AVG_W:0] tgt_ext;
  logic                            heater_nxt, cooler_nxt;

  always_comb begin
    avg_ext    = {avg_status.average[tsdc_pkg::AVG_W-1], avg_status.average};
    tgt_ext    = $signed({2'b00, target_nxt});
    heater_nxt = avg_ext < tgt_ext;
    cooler_nxt = avg_ext > tgt_ext;
  end

  // --------------------------------------------------------------------------
  // Output register. It holds its result while out_stall is high.
  // --------------------------------------------------------------------------
  logic                              heater_r, cooler_r, adjust_r, done_r;
  logic [tsdc_pkg::TEMP_W-1:0]       setpoint_r;
  logic signed [tsdc_pkg::AVG_W-1:0] average_r;

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      heater_r   <= heater_nxt;
      cooler_r   <= cooler_nxt;
      adjust_r   <= mode_nxt;
      setpoint_r <= target_nxt;
      average_r  <= avg_status.average;
      done_r     <= avg_status.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heater_on    = heater_r;
  assign out_cooler_on    = cooler_r;
  assign out_adjust_mode  = adjust_r;
  assign out_setpoint     = setpoint_r;
  assign out_average_temp = average_r;
  assign out_average_done = done_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // An up press in adjust mode below the upper limit raises the setpoint by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op_e == tsdc_pkg::OP_UP) && mode_r && (target_r < max_sp_r))
      |=> (target_r == $past(target_r) + 8'd1))
    else $error("up press did not step the setpoint");

  // A completed average can only come from a sample transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (!out_average_done || ($past(in_op_e) == tsdc_pkg::OP_SAMPLE)))
    else $error("average_done without a sample");

  // Heater and cooler are never driven together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_heater_on && out_cooler_on))
    else $error("heater and cooler both on");

  // A stalled result stays in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(setpoint_r) && $stable(average_r)))
    else $error("stalled result was lost");

endmodule : thermostat_setpoint_deadband_control

`default_nettype wire

[bench/thermostat_setpoint_deadband_control_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermostat_setpoint_deadband_control_tb: self-checking bench for the thermostat
// Drives tick, sample and button events into the controller, mirrors its state
// and settings in a predictor, and checks every result transaction field by
// field. Directed cases come first, then phases of random traffic with
// randomized settings, random gaps on the input side and random stalls on the
// result side.
// ----------------------------------------------------------------------------

module thermostat_setpoint_deadband_control_tb;

  localparam int SAMPLES_PER_AVG = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int MAX_WAIT        = 18;
  // Slowest legal spacing between two accepted transactions is a full input gap
  // plus a full output stall plus the handshake itself, far below this.
  localparam int WATCHDOG_LIMIT  = 500;
  localparam int REPORT_LIMIT    = 10;

  // One result transaction as the controller presents it.
  typedef struct packed {
    logic                              heater_on;
    logic                              cooler_on;
    logic                              adjust_mode;
    logic [tsdc_pkg::TEMP_W-1:0]       setpoint;
    logic signed [tsdc_pkg::AVG_W-1:0] average_temp;
    logic                              average_done;
  } thermo_status_t;

  // All block inputs start at known values; reset is held low from time zero.
  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic [1:0]                  in_op     = tsdc_pkg::OP_TICK;
  logic [tsdc_pkg::TEMP_W-1:0] in_sample = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [1:0]                  cfg_index = tsdc_pkg::CFG_MIN_SETPOINT;
  logic [tsdc_pkg::CFG_W-1:0]  cfg_wdata = '0;

  logic                              in_stall;
  logic                              out_valid;
  logic                              out_heater_on;
  logic                              out_cooler_on;
  logic                              out_adjust_mode;
  logic [tsdc_pkg::TEMP_W-1:0]       out_setpoint;
  logic signed [tsdc_pkg::AVG_W-1:0] out_average_temp;
  logic                              out_average_done;
  logic                              cfg_ready;

  // Predicted controller state and our copy of its settings.
  logic [tsdc_pkg::TEMP_W-1:0] sp_target;
  logic                        adjust_on;
  logic [tsdc_pkg::TICK_W-1:0] idle_ticks;
  logic [tsdc_pkg::SUM_W-1:0]  group_sum;
  int                          group_count;
  int                          latest_avg;
  logic [tsdc_pkg::TEMP_W-1:0] min_sp;
  logic [tsdc_pkg::TEMP_W-1:0] max_sp;
  logic [tsdc_pkg::TICK_W-1:0] timeout_lim;
  logic [tsdc_pkg::TEMP_W-1:0] temp_offset;

  thermo_status_t expected_status_q[$];
  int             fail_count   = 0;
  int             quiet_cycles = 0;
  int             stall_left   = 0;
  bit             no_gaps      = 1'b0;

  thermostat_setpoint_deadband_control #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVG)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_heater_on    (out_heater_on),
    .out_cooler_on    (out_cooler_on),
    .out_adjust_mode  (out_adjust_mode),
    .out_setpoint     (out_setpoint),
    .out_average_temp (out_average_temp),
    .out_average_done (out_average_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Puts the predictor in the state the controller has right after reset.
  function automatic void reset_model();
    min_sp      = 8'd10;
    max_sp      = 8'd40;
    timeout_lim = 16'd5000;
    temp_offset = 8'd5;
    sp_target   = 8'd20;
    adjust_on   = 1'b0;
    idle_ticks  = '0;
    group_sum   = '0;
    group_count = 0;
    latest_avg  = 0;
  endfunction

  // Applies one event to the predicted state and returns the status that the
  // controller should report for it.
  function automatic thermo_status_t advance_thermostat(tsdc_pkg::op_t op,
                                                        logic [tsdc_pkg::TEMP_W-1:0] smp);
    thermo_status_t st;
    int unsigned    next_idle;
    st.average_done = 1'b0;
    case (op)
      tsdc_pkg::OP_TICK: begin
        // Ticks only matter in adjust mode. A limit of zero ends the mode on
        // the first tick, just like a limit of one.
        if (adjust_on) begin
          next_idle = 32'(idle_ticks) + 32'd1;
          if (next_idle >= 32'(timeout_lim)) begin
            adjust_on  = 1'b0;
            idle_ticks = '0;
          end else begin
            idle_ticks = next_idle[tsdc_pkg::TICK_W-1:0];
          end
        end
      end
      tsdc_pkg::OP_SAMPLE: begin
        group_sum   = group_sum + smp;
        group_count = group_count + 1;
        if (group_count >= SAMPLES_PER_AVG) begin
          // Truncated mean; the offset may push it well below zero.
          latest_avg      = int'(group_sum) / SAMPLES_PER_AVG - int'(temp_offset);
          group_sum       = '0;
          group_count     = 0;
          st.average_done = 1'b1;
        end
      end
      default: begin
        // The first press only wakes adjust mode. Each limit is checked on its
        // own, so crossed limits can block both directions and a setpoint outside the range blocks one.
        if (!adjust_on) begin
          adjust_on = 1'b1;
        end else if (op == tsdc_pkg::OP_UP) begin
          if (sp_target < max_sp) sp_target = sp_target + 8'd1;
        end else begin
          if (sp_target > min_sp) sp_target = sp_target - 8'd1;
        end
        idle_ticks = '0;
      end
    endcase
    // Dead band: neither output is on while the average equals the setpoint.
    st.heater_on    = (latest_avg < int'(sp_target));
    st.cooler_on    = (latest_avg > int'(sp_target));
    st.adjust_mode  = adjust_on;
    st.setpoint     = sp_target;
    st.average_temp = tsdc_pkg::AVG_W'(latest_avg);
    return st;
  endfunction

  function automatic int draw_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Only the first few failures are printed; all of them are counted.
  function automatic void note_failure(string msg);
    fail_count = fail_count + 1;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void compare_field(string field, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
    if (got_v !== want_v)
      note_failure($sformatf("%s: expected %0d, got %0d", field, want_v, got_v));
  endfunction

  // Every accepted event and every accepted register write is applied to the
  // predictor at the edge where its handshake completes. Settings only change
  // while no event is in flight, so the two never meet at one edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_status_q.push_back(advance_thermostat(tsdc_pkg::op_t'(in_op), in_sample));
    if (rst_n && cfg_valid && cfg_ready) begin
      case (tsdc_pkg::cfg_idx_t'(cfg_index))
        tsdc_pkg::CFG_MIN_SETPOINT:  min_sp      = cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::CFG_MAX_SETPOINT:  max_sp      = cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::CFG_TIMEOUT_TICKS: timeout_lim = cfg_wdata[tsdc_pkg::TICK_W-1:0];
        tsdc_pkg::CFG_SENSOR_OFFSET: temp_offset = cfg_wdata[tsdc_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Each result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    thermo_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        note_failure("result transaction with no event pending");
      end else begin
        want = expected_status_q.pop_front();
        compare_field("heater_on",    want.heater_on,    out_heater_on);
        compare_field("cooler_on",    want.cooler_on,    out_cooler_on);
        compare_field("adjust_mode",  want.adjust_mode,  out_adjust_mode);
        compare_field("setpoint",     want.setpoint,     out_setpoint);
        compare_field("average_temp", want.average_temp, out_average_temp);
        compare_field("average_done", want.average_done, out_average_done);
      end
    end
  end

  // Result side: after each accepted result, stall for a freshly drawn number
  // of cycles. The count runs down whether or not a result is waiting, so the
  // stalls land on every point of the controller's work.
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = draw_wait();
    else if (stall_left > 0) stall_left = stall_left - 1;
    out_stall <= (stall_left > 0);
  end

  // Watchdog: a long stretch without any handshake means the controller hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one event after a random gap and returns at the edge that takes it.
  // With no gap, valid simply stays high for the next transaction.
  task automatic send_event(tsdc_pkg::op_t op, logic [tsdc_pkg::TEMP_W-1:0] smp);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the input off until every predicted result has been seen.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
  endtask

  // Settings are only touched while the controller has nothing in flight.
  task automatic write_register(tsdc_pkg::cfg_idx_t idx, logic [tsdc_pkg::CFG_W-1:0] data);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Straight out of reset: the average is zero, so the heater is on, and a
  // tick while idle changes nothing.
  task automatic test_reset_state();
    send_event(tsdc_pkg::OP_TICK, 8'h00);
  endtask

  // The first press only enters adjust mode; later presses step the setpoint.
  task automatic test_press_entry();
    send_event(tsdc_pkg::OP_UP, 8'hFF);
    send_event(tsdc_pkg::OP_UP, 8'h00);
    send_event(tsdc_pkg::OP_DOWN, 8'hA5);
  endtask

  // Adjust mode ends when the idle count reaches its limit, and at once when
  // the limit is zero.
  task automatic test_timeout();
    write_register(tsdc_pkg::CFG_TIMEOUT_TICKS, 16'd2);
    send_event(tsdc_pkg::OP_TICK, 8'h00);
    send_event(tsdc_pkg::OP_TICK, 8'h00);
    write_register(tsdc_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    send_event(tsdc_pkg::OP_DOWN, 8'h00);
    send_event(tsdc_pkg::OP_TICK, 8'h00);
  endtask

  // Clamping at each limit, crossed limits, and a setpoint outside the range.
  task automatic test_setpoint_limits();
    write_register(tsdc_pkg::CFG_MIN_SETPOINT, 16'd19);
    write_register(tsdc_pkg::CFG_MAX_SETPOINT, 16'd21);
    send_event(tsdc_pkg::OP_UP, 8'h00);
    send_event(tsdc_pkg::OP_UP, 8'h00);
    send_event(tsdc_pkg::OP_UP, 8'h00);
    // Crossed: neither direction may move.
    write_register(tsdc_pkg::CFG_MIN_SETPOINT, 16'd255);
    write_register(tsdc_pkg::CFG_MAX_SETPOINT, 16'd0);
    send_event(tsdc_pkg::OP_DOWN, 8'h00);
    send_event(tsdc_pkg::OP_UP, 8'h00);
    // Below the range: down is blocked, up still steps toward it.
    write_register(tsdc_pkg::CFG_MIN_SETPOINT, 16'd30);
    write_register(tsdc_pkg::CFG_MAX_SETPOINT, 16'd40);
    send_event(tsdc_pkg::OP_DOWN, 8'h00);
    send_event(tsdc_pkg::OP_UP, 8'h00);
  endtask

  // One full group with both sample extremes and no offset.
  task automatic test_sample_average();
    write_register(tsdc_pkg::CFG_SENSOR_OFFSET, 16'd0);
    send_event(tsdc_pkg::OP_SAMPLE, 8'h00);
    repeat (SAMPLES_PER_AVG - 1) send_event(tsdc_pkg::OP_SAMPLE, 8'hFF);
  endtask

  // One random event. Samples are often drawn close to setpoint plus offset
  // so that averages land in and around the dead band.
  task automatic send_random_event(int press_pct, int up_pct);
    tsdc_pkg::op_t               op;
    logic [tsdc_pkg::TEMP_W-1:0] smp;
    int                          near_val;
    if ($urandom_range(0, 99) < press_pct)
      op = ($urandom_range(0, 99) < up_pct) ? tsdc_pkg::OP_UP : tsdc_pkg::OP_DOWN;
    else if ($urandom_range(0, 99) < 60)
      op = tsdc_pkg::OP_SAMPLE;
    else
      op = tsdc_pkg::OP_TICK;
    case ($urandom_range(0, 3))
      0: begin
        near_val = int'(sp_target) + int'(temp_offset) + int'($urandom_range(0, 4)) - 2;
        if (near_val < 0) near_val = 0;
        else if (near_val > 255) near_val = 255;
        smp = near_val[tsdc_pkg::TEMP_W-1:0];
      end
      1: smp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: smp = tsdc_pkg::TEMP_W'($urandom_range(0, 255));
    endcase
    send_event(op, smp);
  endtask

  // Programs all four settings, then runs a stretch of random events. Gap-free
  // bursts and full drains of the result side are mixed in along the way.
  task automatic run_random_phase(int lo, int hi, int ticks, int offset, int count,
                                  int press_pct, int up_pct);
    write_register(tsdc_pkg::CFG_MIN_SETPOINT, tsdc_pkg::CFG_W'(lo));
    write_register(tsdc_pkg::CFG_MAX_SETPOINT, tsdc_pkg::CFG_W'(hi));
    write_register(tsdc_pkg::CFG_TIMEOUT_TICKS, tsdc_pkg::CFG_W'(ticks));
    write_register(tsdc_pkg::CFG_SENSOR_OFFSET, tsdc_pkg::CFG_W'(offset));
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n % 50 == 25 && $urandom_range(0, 2) == 0) wait_for_results();
      send_random_event(press_pct, up_pct);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase($urandom_range(5, 25), $urandom_range(30, 60), $urandom_range(1, 6),
                     5, 75, 30, 50);
    run_random_phase(0, 255, 0, $urandom_range(0, 255), 75, 30, 50);
    // Crossed limits with a short timeout.
    run_random_phase($urandom_range(30, 60), $urandom_range(0, 25), $urandom_range(1, 4),
                     $urandom_range(0, 255), 75, 40, 50);
    // Press-heavy runs that drive the setpoint far up, then back down.
    run_random_phase(0, 255, 65535, 0, 260, 90, 98);
    run_random_phase(0, 255, 3, 255, 260, 90, 2);
    run_random_phase(255, 0, 1, 255, 75, 30, 50);
    run_random_phase($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, 255), 75, 30, 50);
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_press_entry();
    test_timeout();
    test_setpoint_limits();
    test_sample_average();
    test_random_traffic();

    // Let the last results drain, then keep the clock running so that any stray
    // transaction shows up.
    wait_for_results();
    repeat (4) @(posedge clk);
    if (expected_status_q.size() != 0) note_failure("predicted results never arrived");

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
